### hdl/gdc_pkg.sv
// Shared types, codes and calendar tables for the Gregorian date counter.
package gdc_pkg;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ADD    = 2'd1,
		OP_SUB    = 2'd2,
		OP_FRIDAY = 2'd3
	} gdc_op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_LOAD = 2'd1,
		STAT_LIMIT    = 2'd2
	} gdc_status_t;

	typedef struct packed {
		logic capture;
		logic use_load;
		logic exec;
		logic step;
		logic out_load;
	} gdc_cmd_t;

	typedef struct packed {
		logic step_done;
	} gdc_sts_t;

	localparam logic [13:0] YEAR_MIN   = 14'd1;
	localparam logic [13:0] YEAR_MAX   = 14'd9999;
	localparam logic [12:0] RECIP_100  = 13'd5243;   // 2^19 / 100, rounded up
	localparam logic [15:0] RECIP_7    = 16'd37450;  // 2^18 / 7, rounded up
	localparam int          WAIT_STEPS = 6;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// 31 * m / 12 for the March-based month index
	function automatic logic [4:0] month_term(input logic [3:0] m);
		logic [4:0] t;
		unique case (m)
			4'd1:    t = 5'd2;
			4'd2:    t = 5'd5;
			4'd3:    t = 5'd7;
			4'd4:    t = 5'd10;
			4'd5:    t = 5'd12;
			4'd6:    t = 5'd15;
			4'd7:    t = 5'd18;
			4'd8:    t = 5'd20;
			4'd9:    t = 5'd23;
			4'd10:   t = 5'd25;
			4'd11:   t = 5'd28;
			4'd12:   t = 5'd31;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

endpackage

### hdl/gdc_ctrl.sv
// Sequencing state machine and output word handshake for the date counter.
module gdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  gdc_pkg::gdc_sts_t sts,
	output gdc_pkg::gdc_cmd_t cmd
);
	import gdc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_PREP   = 6'b000010,
		S_EXEC   = 6'b000100,
		S_STEP   = 6'b001000,
		S_SETTLE = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	localparam logic [2:0] WAIT_LAST = 3'(WAIT_STEPS - 1);

	state_t     state_q, state_nxt;
	logic [2:0] wait_q;
	logic       out_valid_q;
	logic       out_free;
	logic       waiting;

	assign out_free  = !out_valid_q || !out_stall;
	assign waiting   = (state_q == S_PREP) || (state_q == S_SETTLE);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_nxt = S_PREP;
			end
			S_PREP: begin
				// load year feeds the leap pipe until the prep wait reaches its last step
				cmd.use_load = (wait_q != WAIT_LAST);
				if (wait_q == WAIT_LAST) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = S_STEP;
			end
			S_STEP: begin
				if (sts.step_done) state_nxt = S_SETTLE;
				else cmd.step = 1'b1;
			end
			S_SETTLE: begin
				if (wait_q == WAIT_LAST) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (waiting && wait_q != WAIT_LAST) wait_q <= wait_q + 3'd1;
			else wait_q <= '0;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

### hdl/gdc_dp.sv
// Date registers, day stepper, leap and weekday pipelines, output word registers.
module gdc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  gdc_pkg::gdc_cmd_t cmd,
	output gdc_pkg::gdc_sts_t sts,
	input  logic [1:0]        opcode,
	input  logic [4:0]        load_day,
	input  logic [3:0]        load_month,
	input  logic [13:0]       load_year,
	input  logic [7:0]        day_count,
	output logic [4:0]        cur_day,
	output logic [3:0]        cur_month,
	output logic [13:0]       cur_year,
	output logic [2:0]        weekday,
	output logic              leap_flag,
	output logic [4:0]        month_length,
	output logic [1:0]        status
);
	import gdc_pkg::*;

	gdc_op_t     op_q;
	logic [4:0]  ld_q;
	logic [3:0]  lm_q;
	logic [13:0] ly_q;
	logic [7:0]  cnt_q;

	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [13:0] year_q;
	logic [7:0]  count_q;
	logic        limit_q;
	gdc_status_t status_q;

	// leap pipeline
	logic [13:0] ly_src;
	logic [13:0] ly_y_s1;
	logic [26:0] ly_prod_s1;
	logic [7:0]  ly_q100;
	logic [13:0] ly_hund;
	logic        ly_leap_s2;

	// weekday pipeline
	logic        wk_early;
	logic [13:0] wk_yadj;
	logic [3:0]  wk_madj;
	logic [5:0]  wk_base_s1;
	logic [13:0] wk_y_s1;
	logic [26:0] wk_prod_s1;
	logic [7:0]  wk_q100;
	logic [13:0] wk_sum_s2;
	logic [13:0] wk_sum_s3;
	logic [29:0] wk_prod_s3;
	logic [10:0] wk_q7;
	logic [13:0] wk_rem;
	logic [2:0]  wk_day_s4;

	logic [4:0]  cur_len;
	logic [3:0]  month_prev;
	logic        load_ok;
	logic [2:0]  fri_gap;

	assign ly_src = cmd.use_load ? ly_q : year_q;

	always_ff @(posedge clk) begin
		ly_y_s1    <= ly_src;
		ly_prod_s1 <= 27'(ly_src) * 27'(RECIP_100);
		ly_leap_s2 <= (ly_y_s1[1:0] == 2'd0) && ((ly_y_s1 != ly_hund) || (ly_q100[1:0] == 2'd0));
	end

	assign ly_q100 = ly_prod_s1[26:19];
	assign ly_hund = {6'd0, ly_q100} * 14'd100;

	assign wk_early = (month_q < 4'd3);
	assign wk_yadj  = wk_early ? year_q - 14'd1 : year_q;
	assign wk_madj  = wk_early ? month_q + 4'd10 : month_q - 4'd2;
	assign wk_q100  = wk_prod_s1[26:19];
	assign wk_q7    = wk_prod_s3[28:18];
	assign wk_rem   = wk_sum_s3 - 14'({3'd0, wk_q7} * 14'd7);

	always_ff @(posedge clk) begin
		wk_base_s1 <= 6'(day_q) + 6'(month_term(wk_madj));
		wk_y_s1    <= wk_yadj;
		wk_prod_s1 <= 27'(wk_yadj) * 27'(RECIP_100);
		wk_sum_s2  <= 14'(wk_base_s1) + wk_y_s1 + (wk_y_s1 >> 2)
			- 14'(wk_q100) + 14'(wk_q100 >> 2);
		wk_sum_s3  <= wk_sum_s2;
		wk_prod_s3 <= 30'(wk_sum_s2) * 30'(RECIP_7);
		wk_day_s4  <= (wk_rem[2:0] == 3'd0) ? 3'd7 : wk_rem[2:0];
	end

	assign cur_len    = month_len(month_q, ly_leap_s2);
	assign month_prev = month_q - 4'd1;
	assign load_ok    = (lm_q >= 4'd1) && (lm_q <= 4'd12) && (ly_q >= YEAR_MIN)
		&& (ly_q <= YEAR_MAX) && (ld_q >= 5'd1) && (ld_q <= month_len(lm_q, ly_leap_s2));
	assign fri_gap    = (wk_day_s4 <= 3'd5) ? 3'd5 - wk_day_s4 : 3'(4'd12 - 4'(wk_day_s4));

	assign sts.step_done = (count_q == 8'd0) || limit_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= gdc_op_t'(opcode);
			ld_q  <= load_day;
			lm_q  <= load_month;
			ly_q  <= load_year;
			cnt_q <= day_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q    <= 5'd1;
			month_q  <= 4'd1;
			year_q   <= 14'd2000;
			count_q  <= '0;
			limit_q  <= 1'b0;
			status_q <= STAT_OK;
		end else begin
			priority if (cmd.exec) begin
				limit_q <= 1'b0;
				unique case (op_q)
					OP_LOAD: begin
						count_q <= '0;
						if (load_ok) begin
							day_q    <= ld_q;
							month_q  <= lm_q;
							year_q   <= ly_q;
							status_q <= STAT_OK;
						end else begin
							status_q <= STAT_BAD_LOAD;
						end
					end
					OP_ADD, OP_SUB: begin
						count_q  <= cnt_q;
						status_q <= STAT_OK;
					end
					OP_FRIDAY: begin
						count_q  <= 8'(fri_gap);
						status_q <= STAT_OK;
					end
					default: count_q <= '0;
				endcase
			end else if (cmd.step) begin
				if (op_q == OP_SUB) begin
					if (day_q <= 5'd1) begin
						if (month_q <= 4'd1) begin
							if (year_q <= YEAR_MIN) begin
								limit_q  <= 1'b1;
								status_q <= STAT_LIMIT;
							end else begin
								year_q  <= year_q - 14'd1;
								month_q <= 4'd12;
								day_q   <= 5'd31;
								count_q <= count_q - 8'd1;
							end
						end else begin
							month_q <= month_prev;
							day_q   <= month_len(month_prev, ly_leap_s2);
							count_q <= count_q - 8'd1;
						end
					end else begin
						day_q   <= day_q - 5'd1;
						count_q <= count_q - 8'd1;
					end
				end else begin
					if (day_q >= cur_len) begin
						if (month_q >= 4'd12) begin
							if (year_q >= YEAR_MAX) begin
								limit_q  <= 1'b1;
								status_q <= STAT_LIMIT;
							end else begin
								year_q  <= year_q + 14'd1;
								month_q <= 4'd1;
								day_q   <= 5'd1;
								count_q <= count_q - 8'd1;
							end
						end else begin
							month_q <= month_q + 4'd1;
							day_q   <= 5'd1;
							count_q <= count_q - 8'd1;
						end
					end else begin
						day_q   <= day_q + 5'd1;
						count_q <= count_q - 8'd1;
					end
				end
			end else begin
				count_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cur_day      <= day_q;
			cur_month    <= month_q;
			cur_year     <= year_q;
			weekday      <= wk_day_s4;
			leap_flag    <= ly_leap_s2;
			month_length <= cur_len;
			status       <= status_q;
		end
	end

endmodule

### hdl/gregorian_date_counter_core.sv
// Each accepted word steps the date by n days, n = 0..255 (Friday 0..6).
// A new word is taken only once the previous result has gone to the output register.
// The leap and weekday pipelines settle in a wait before and after stepping.
// Reset: asynchronous, active low; date returns to 1 January 2000, no result pending.
// A finished result waits in the output register while the next word is taken.
// Top level of the Gregorian date counter.
module gregorian_date_counter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [4:0]  load_day,
	input  logic [3:0]  load_month,
	input  logic [13:0] load_year,
	input  logic [7:0]  day_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  cur_day,
	output logic [3:0]  cur_month,
	output logic [13:0] cur_year,
	output logic [2:0]  weekday,
	output logic        leap_flag,
	output logic [4:0]  month_length,
	output logic [1:0]  status
);
	import gdc_pkg::*;

	gdc_cmd_t cmd;
	gdc_sts_t sts;

	gdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gdc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.load_day     (load_day),
		.load_month   (load_month),
		.load_year    (load_year),
		.day_count    (day_count),
		.cur_day      (cur_day),
		.cur_month    (cur_month),
		.cur_year     (cur_year),
		.weekday      (weekday),
		.leap_flag    (leap_flag),
		.month_length (month_length),
		.status       (status)
	);

endmodule

### sim/gregorian_date_counter_core_tb.sv
// Self-checking testbench for the Gregorian date counter: directed and random commands.
module gregorian_date_counter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gdc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int HOLD_CYCLES    = 500;

	typedef struct {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [2:0]  wday;
		logic        leap;
		logic [4:0]  mlen;
		gdc_status_t stat;
	} date_report_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [4:0]  load_day;
	logic [3:0]  load_month;
	logic [13:0] load_year;
	logic [7:0]  day_count;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  cur_day;
	logic [3:0]  cur_month;
	logic [13:0] cur_year;
	logic [2:0]  weekday;
	logic        leap_flag;
	logic [4:0]  month_length;
	logic [1:0]  status;

	// calendar state as the block should hold it
	int unsigned cal_day;
	int unsigned cal_month;
	int unsigned cal_year;

	date_report_t pending_reports[$];
	int  mismatches;
	int  words_sent;
	int  reports_checked;
	int  rejected_loads;
	int  limit_stops;
	int  quiet_cycles;
	bit  idling;
	bit  hold_req;

	gregorian_date_counter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.load_day(load_day),
		.load_month(load_month),
		.load_year(load_year),
		.day_count(day_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cur_day(cur_day),
		.cur_month(cur_month),
		.cur_year(cur_year),
		.weekday(weekday),
		.leap_flag(leap_flag),
		.month_length(month_length),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic bit is_leap_year(input int unsigned y);
		if (y % 100 == 0)
			return (y % 400 == 0);
		return (y % 4 == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		case (m)
			2:           return is_leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	function automatic int unsigned day_of_week(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned w;
		if (m < 3) begin
			y = y - 1;
			m = m + 10;
		end else begin
			m = m - 2;
		end
		w = (d + 31 * m / 12 + y + y / 4 - y / 100 + y / 400) % 7;
		return (w == 0) ? 7 : w;
	endfunction

	// returns 1 when the top of the year range stops the walk
	function automatic bit walk_forward(input int unsigned n);
		while (n > 0) begin
			if (cal_day >= days_in_month(cal_month, cal_year)) begin
				if (cal_month >= 12) begin
					if (cal_year >= YEAR_MAX)
						return 1'b1;
					cal_day = 1;
					cal_month = 1;
					cal_year = cal_year + 1;
				end else begin
					cal_day = 1;
					cal_month = cal_month + 1;
				end
			end else begin
				cal_day = cal_day + 1;
			end
			n--;
		end
		return 1'b0;
	endfunction

	function automatic bit walk_back(input int unsigned n);
		while (n > 0) begin
			if (cal_day <= 1) begin
				if (cal_month <= 1) begin
					if (cal_year <= YEAR_MIN)
						return 1'b1;
					cal_year = cal_year - 1;
					cal_month = 12;
				end else begin
					cal_month = cal_month - 1;
				end
				cal_day = days_in_month(cal_month, cal_year);
			end else begin
				cal_day = cal_day - 1;
			end
			n--;
		end
		return 1'b0;
	endfunction

	function automatic date_report_t apply_command(input gdc_op_t op, input int unsigned d,
			input int unsigned m, input int unsigned y, input int unsigned cnt);
		date_report_t r;
		int unsigned wd;
		r.stat = STAT_OK;
		case (op)
			OP_LOAD: begin
				if (m >= 1 && m <= 12 && y >= YEAR_MIN && y <= YEAR_MAX && d >= 1
						&& d <= days_in_month(m, y)) begin
					cal_day = d;
					cal_month = m;
					cal_year = y;
				end else begin
					r.stat = STAT_BAD_LOAD;
				end
			end
			OP_ADD: if (walk_forward(cnt)) r.stat = STAT_LIMIT;
			OP_SUB: if (walk_back(cnt)) r.stat = STAT_LIMIT;
			default: begin
				wd = day_of_week(cal_day, cal_month, cal_year);
				if (walk_forward((wd <= 5) ? 5 - wd : 12 - wd))
					r.stat = STAT_LIMIT;
			end
		endcase
		r.day = 5'(cal_day);
		r.month = 4'(cal_month);
		r.year = 14'(cal_year);
		r.wday = 3'(day_of_week(cal_day, cal_month, cal_year));
		r.leap = is_leap_year(cal_year);
		r.mlen = 5'(days_in_month(cal_month, cal_year));
		return r;
	endfunction

	task automatic send_word(input gdc_op_t op, input int unsigned d, input int unsigned m,
			input int unsigned y, input int unsigned cnt);
		int gap;
		date_report_t r;
		gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode = op;
		load_day = d[4:0];
		load_month = m[3:0];
		load_year = y[13:0];
		day_count = cnt[7:0];
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		r = apply_command(op, d % 32, m % 16, y % 16384, cnt % 256);
		if (r.stat == STAT_BAD_LOAD)
			rejected_loads++;
		if (r.stat == STAT_LIMIT)
			limit_stops++;
		pending_reports.push_back(r);
		words_sent++;
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		date_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t ns: unexpected result word, expected none, actual %0d/%0d/%0d",
					$time, cur_day, cur_month, cur_year);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("cur_day", 32'(want.day), 32'(cur_day));
				check_field("cur_month", 32'(want.month), 32'(cur_month));
				check_field("cur_year", 32'(want.year), 32'(cur_year));
				check_field("weekday", 32'(want.wday), 32'(weekday));
				check_field("leap_flag", 32'(want.leap), 32'(leap_flag));
				check_field("month_length", 32'(want.mlen), 32'(month_length));
				check_field("status", 32'(want.stat), 32'(status));
				reports_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stall bursts, plus a long hold when asked
	initial begin : result_sink
		int stall_left;
		int hold_left;
		bit hold_seen;
		stall_left = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				stall_left = $urandom_range(0, 17);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	task automatic test_reset_state();
		send_word(OP_ADD, 31, 15, 16383, 0);
		send_word(OP_SUB, 31, 15, 16383, 0);
	endtask

	task automatic test_load_checks();
		send_word(OP_LOAD, 31, 15, 16383, 255);
		send_word(OP_LOAD, 0, 6, 2020, 0);
		send_word(OP_LOAD, 15, 0, 2020, 0);
		send_word(OP_LOAD, 15, 13, 2020, 0);
		send_word(OP_LOAD, 15, 6, 0, 0);
		send_word(OP_LOAD, 15, 6, 10000, 0);
		send_word(OP_LOAD, 29, 2, 1900, 0);
		send_word(OP_LOAD, 29, 2, 2000, 0);
		send_word(OP_LOAD, 31, 4, 2021, 0);
	endtask

	task automatic test_year_limits();
		send_word(OP_LOAD, 31, 12, 9999, 0);
		send_word(OP_ADD, 0, 0, 0, 1);
		send_word(OP_LOAD, 20, 12, 9999, 0);
		send_word(OP_ADD, 0, 0, 0, 255);
		send_word(OP_LOAD, 1, 1, 1, 0);
		send_word(OP_SUB, 0, 0, 0, 1);
		send_word(OP_LOAD, 5, 1, 1, 0);
		send_word(OP_SUB, 0, 0, 0, 255);
	endtask

	task automatic test_year_crossing();
		send_word(OP_LOAD, 1, 1, 2001, 0);
		send_word(OP_SUB, 0, 0, 0, 1);
		send_word(OP_LOAD, 1, 3, 2000, 0);
		send_word(OP_SUB, 0, 0, 0, 1);
	endtask

	task automatic test_next_friday();
		send_word(OP_LOAD, 30, 12, 9999, 0);
		send_word(OP_FRIDAY, 31, 15, 16383, 255);
		send_word(OP_FRIDAY, 0, 0, 0, 0);
	endtask

	task automatic test_random_commands(input int count, input bit allow_idle);
		int unsigned r;
		int unsigned d;
		int unsigned m;
		int unsigned y;
		gdc_op_t     op;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				idling = allow_idle && ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 25) begin
				if ($urandom_range(0, 3) == 0) begin
					d = $urandom_range(0, 31);
					m = $urandom_range(0, 15);
					y = $urandom_range(0, 16383);
				end else begin
					case ($urandom_range(0, 9))
						0:       y = $urandom_range(1, 3);
						1:       y = $urandom_range(9997, 9999);
						2:       y = 100 * $urandom_range(1, 99);
						default: y = $urandom_range(1, 9999);
					endcase
					m = $urandom_range(1, 12);
					d = $urandom_range(1, days_in_month(m, y));
				end
				send_word(OP_LOAD, d, m, y, $urandom_range(0, 255));
			end else begin
				op = (r < 55) ? OP_ADD : (r < 85) ? OP_SUB : OP_FRIDAY;
				send_word(op, $urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(0, 16383), $urandom_range(0, 255));
			end
		end
	endtask

	// receiver holds off while short words keep coming, so the block backs up
	task automatic test_backpressure();
		idling = 1'b0;
		@(negedge clk);
		hold_req = 1'b1;
		send_word(OP_LOAD, 28, 2, 2024, 0);
		for (int i = 0; i < 10; i++)
			send_word((i % 2 == 0) ? OP_ADD : OP_SUB, 0, 0, 0, $urandom_range(0, 3));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_LOAD;
		load_day = '0;
		load_month = '0;
		load_year = '0;
		day_count = '0;
		hold_req = 1'b0;
		idling = 1'b1;
		words_sent = 0;
		rejected_loads = 0;
		limit_stops = 0;
		cal_day = 1;
		cal_month = 1;
		cal_year = 2000;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_load_checks();
		test_year_limits();
		test_year_crossing();
		test_next_friday();
		test_random_commands(1400, 1'b1);
		test_backpressure();
		test_random_commands(400, 1'b0);

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands (loads, day steps both ways, next Friday), %0d results checked.",
			words_sent, reports_checked);
		$display("Seen %0d rejected loads and %0d stops at the year range limit.",
			rejected_loads, limit_stops);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
